[hw/rtl/olid_pkg.sv]
// ----------------------------------------------------------------------------
// olid_pkg: shared types and constants for the ordered list block
// Request codes, status codes, the command word and derived widths.
// ----------------------------------------------------------------------------
package olid_pkg;

	localparam int CAPACITY = 8;
	localparam int VAL_W    = 32;
	localparam int POS_W    = 3;
	localparam int REQ_W    = 3;
	localparam int STAT_W   = 2;
	localparam int EC_W     = 4;

	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int IDX_W = $clog2(CAPACITY);
	localparam int EXT_W = (CNT_W > POS_W) ? ((CNT_W > EC_W) ? CNT_W : EC_W)
	                                       : ((POS_W > EC_W) ? POS_W : EC_W);

	localparam int S_DATA_W = ((VAL_W + POS_W + 7) / 8) * 8;
	localparam int M_DATA_W = ((VAL_W + EC_W + 7) / 8) * 8;

	localparam int QDEPTH = 2;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	typedef enum logic [REQ_W-1:0] {
		REQ_INS_FRONT = 3'd0,
		REQ_INS_BACK  = 3'd1,
		REQ_INS_POS   = 3'd2,
		REQ_REM_FRONT = 3'd3,
		REQ_REM_BACK  = 3'd4,
		REQ_REM_POS   = 3'd5
	} req_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK     = 2'd0,
		ST_FULL   = 2'd1,
		ST_EMPTY  = 2'd2,
		ST_BADPOS = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		K_NOP = 2'd0,
		K_INS = 2'd1,
		K_REM = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		W_FRONT = 2'd0,
		W_BACK  = 2'd1,
		W_POS   = 2'd2
	} where_t;

	typedef struct packed {
		kind_t                   kind;
		where_t                  where;
		logic signed [VAL_W-1:0] value;
		logic [POS_W-1:0]        position;
	} cmd_t;

endpackage

[hw/rtl/ordered_list_insert_delete.sv]
// ----------------------------------------------------------------------------
// ordered_list_insert_delete: ordered list with insert and remove
// Fixed-capacity list of signed 32-bit values, edited by requests.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on the s_ stream: s_tuser carries the request code,
//   s_tdata the value and position. Each request gives exactly one result
//   on the m_ stream: m_tuser carries the status, m_tdata the removed value
//   and the entry count after the request.
//   An intake register decodes requests into a two-entry command queue; the
//   list engine drains the queue, shifting all cells in parallel, and holds
//   its result in an output register.
//   A request passes the intake register, queue and output register in order.
//   Throughput is one request per cycle unless m_tready stalls the output.
//   Reset empties the list (count zero) and clears all valid flags.
//   When m_tready is low the result waits in the output register; up to
//   three further requests are absorbed by the intake register and queue
//   before s_tready drops.
// ----------------------------------------------------------------------------
module ordered_list_insert_delete (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// [31:0] value, [34:32] position, rest zero
	input  logic [olid_pkg::S_DATA_W-1:0]  s_tdata,
	// [2:0] req_type
	input  logic [olid_pkg::REQ_W-1:0]     s_tuser,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// [31:0] removed_value, [35:32] entry_count, rest zero
	output logic [olid_pkg::M_DATA_W-1:0]  m_tdata,
	// [1:0] status
	output logic [olid_pkg::STAT_W-1:0]    m_tuser
);
	import olid_pkg::*;

	logic fr_valid;
	logic fr_ready;
	cmd_t fr_cmd;
	logic q_valid;
	logic q_ready;
	cmd_t q_cmd;

	olid_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.cmd_valid (fr_valid),
		.cmd_ready (fr_ready),
		.cmd       (fr_cmd)
	);

	olid_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (fr_valid),
		.in_ready  (fr_ready),
		.in_cmd    (fr_cmd),
		.out_valid (q_valid),
		.out_ready (q_ready),
		.out_cmd   (q_cmd)
	);

	olid_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (q_valid),
		.cmd_ready (q_ready),
		.cmd       (q_cmd),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[VAL_W +: EC_W] <= EC_W'(CAPACITY)))
		else $error("entry count above capacity");

	a_fail_no_value: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser != ST_OK) |-> (m_tdata[VAL_W-1:0] == '0))
		else $error("failed request returned a value");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser == ST_FULL) |-> (m_tdata[VAL_W +: EC_W] == EC_W'(CAPACITY)))
		else $error("full status with list not full");

	a_empty_count: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser == ST_EMPTY) |-> (m_tdata[VAL_W +: EC_W] == '0))
		else $error("empty status with list not empty");

endmodule

[hw/rtl/olid_front.sv]
// ----------------------------------------------------------------------------
// olid_front: request intake
// Registers incoming requests and decodes the request code into a command.
// ----------------------------------------------------------------------------
module olid_front (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [olid_pkg::S_DATA_W-1:0]  s_tdata,
	input  logic [olid_pkg::REQ_W-1:0]     s_tuser,
	output logic                           cmd_valid,
	input  logic                           cmd_ready,
	output olid_pkg::cmd_t                 cmd
);
	import olid_pkg::*;

	logic valid_s1;
	cmd_t cmd_s1;
	cmd_t dec;

	always_comb begin
		dec.value    = s_tdata[VAL_W-1:0];
		dec.position = s_tdata[VAL_W +: POS_W];
		case (req_t'(s_tuser))
			REQ_INS_FRONT: begin dec.kind = K_INS; dec.where = W_FRONT; end
			REQ_INS_BACK:  begin dec.kind = K_INS; dec.where = W_BACK;  end
			REQ_INS_POS:   begin dec.kind = K_INS; dec.where = W_POS;   end
			REQ_REM_FRONT: begin dec.kind = K_REM; dec.where = W_FRONT; end
			REQ_REM_BACK:  begin dec.kind = K_REM; dec.where = W_BACK;  end
			REQ_REM_POS:   begin dec.kind = K_REM; dec.where = W_POS;   end
			default:       begin dec.kind = K_NOP; dec.where = W_FRONT; end
		endcase
	end

	assign s_tready  = !valid_s1 || cmd_ready;
	assign cmd_valid = valid_s1;
	assign cmd       = cmd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			cmd_s1 <= dec;
		end
	end

endmodule

[hw/rtl/olid_queue.sv]
// ----------------------------------------------------------------------------
// olid_queue: command queue
// Short FIFO between intake and the list engine.
// ----------------------------------------------------------------------------
module olid_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  olid_pkg::cmd_t in_cmd,
	output logic           out_valid,
	input  logic           out_ready,
	output olid_pkg::cmd_t out_cmd
);
	import olid_pkg::*;

	cmd_t              slot_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] fill_q;
	logic              push;
	logic              pop;

	assign in_ready  = fill_q != QCNT_W'(QDEPTH);
	assign out_valid = fill_q != '0;
	assign out_cmd   = slot_q[rd_ptr_q];
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   fill_q <= fill_q + 1'b1;
				2'b01:   fill_q <= fill_q - 1'b1;
				default: fill_q <= fill_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= in_cmd;
		end
	end

endmodule

[hw/rtl/olid_back.sv]
// ----------------------------------------------------------------------------
// olid_back: list engine
// Shift-register cells holding the list; checks and executes one command
// per cycle while the result register is free or being read, and registers the result.
// ----------------------------------------------------------------------------
module olid_back (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cmd_valid,
	output logic                           cmd_ready,
	input  olid_pkg::cmd_t                 cmd,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [olid_pkg::M_DATA_W-1:0]  m_tdata,
	output logic [olid_pkg::STAT_W-1:0]    m_tuser
);
	import olid_pkg::*;

	logic [VAL_W-1:0] entries_q [CAPACITY];
	logic [VAL_W-1:0] up_e      [CAPACITY];
	logic [VAL_W-1:0] dn_e      [CAPACITY];
	logic [CNT_W-1:0] count_q;

	logic             res_valid_q;
	status_t          status_q;
	logic [VAL_W-1:0] removed_q;
	logic [EC_W-1:0]  ec_q;

	logic             take;
	status_t          status;
	logic [CNT_W-1:0] idx;
	logic [IDX_W-1:0] idx_i;
	logic [EXT_W-1:0] pos_ext;
	logic [EXT_W-1:0] cnt_ext;
	logic             do_ins;
	logic             do_rem;
	logic [CNT_W-1:0] count_nxt;
	logic [VAL_W-1:0] removed;

	assign cmd_ready = !res_valid_q || m_tready;
	assign take      = cmd_valid && cmd_ready;
	assign pos_ext   = EXT_W'(cmd.position);
	assign cnt_ext   = EXT_W'(count_q);

	// check the request against the current fill
	always_comb begin
		status = ST_OK;
		case (cmd.kind)
			K_INS: begin
				if (count_q == CNT_W'(CAPACITY)) begin
					status = ST_FULL;
				end else if (cmd.where == W_POS && pos_ext > cnt_ext) begin
					status = ST_BADPOS;
				end
			end
			K_REM: begin
				if (count_q == '0) begin
					status = ST_EMPTY;
				end else if (cmd.where == W_POS && pos_ext >= cnt_ext) begin
					status = ST_BADPOS;
				end
			end
			default: status = ST_OK;
		endcase
	end

	always_comb begin
		case (cmd.where)
			W_FRONT: idx = '0;
			W_BACK:  idx = (cmd.kind == K_REM) ? count_q - 1'b1 : count_q;
			W_POS:   idx = CNT_W'(pos_ext);
			default: idx = '0;
		endcase
	end

	assign idx_i   = IDX_W'(idx);
	assign do_ins  = cmd.kind == K_INS && status == ST_OK;
	assign do_rem  = cmd.kind == K_REM && status == ST_OK;
	assign removed = do_rem ? entries_q[idx_i] : '0;

	always_comb begin
		count_nxt = count_q;
		if (do_ins) begin
			count_nxt = count_q + 1'b1;
		end else if (do_rem) begin
			count_nxt = count_q - 1'b1;
		end
	end

	// neighbor taps for the shift cells
	always_comb begin
		up_e[0] = cmd.value;
		for (int i = 1; i < CAPACITY; i++) begin
			up_e[i] = entries_q[i-1];
		end
		for (int i = 0; i < CAPACITY - 1; i++) begin
			dn_e[i] = entries_q[i+1];
		end
		dn_e[CAPACITY-1] = entries_q[CAPACITY-1];
	end

	always_ff @(posedge clk) begin
		if (take && (do_ins || do_rem)) begin
			for (int i = 0; i < CAPACITY; i++) begin
				if (IDX_W'(i) == idx_i) begin
					entries_q[i] <= do_ins ? cmd.value : dn_e[i];
				end else if (IDX_W'(i) > idx_i) begin
					entries_q[i] <= do_ins ? up_e[i] : dn_e[i];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (take) begin
				count_q <= count_nxt;
			end
			if (cmd_ready) begin
				res_valid_q <= cmd_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			status_q  <= status;
			removed_q <= removed;
			ec_q      <= EC_W'(count_nxt);
		end
	end

	assign m_tvalid = res_valid_q;
	assign m_tuser  = status_q;
	assign m_tdata  = M_DATA_W'({ec_q, removed_q});

endmodule
